// ===== rtl/scancode_to_ascii_key_queue_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the scancode key queue
// Concurrent assertion shorthands clocked on i_clk, with and without reset.
// ---------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_KEY_QUEUE_MACROS_SVH
`define SCANCODE_TO_ASCII_KEY_QUEUE_MACROS_SVH

// Checked at every edge, reset included.
`define SAKQ_ASSERT(lbl, pr, msg) \
    lbl: assert property (@(posedge i_clk) pr) else $error(msg);

// Checked only while reset is released.
`define SAKQ_ASSERT_RUN(lbl, pr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) pr) else $error(msg);

`endif

// ===== rtl/sakq_pkg.sv =====
// ---------------------------------------------------------------------------
// sakq_pkg
// Types, scancode codes and key tables shared by the scancode key queue.
// ---------------------------------------------------------------------------
`default_nettype none

package sakq_pkg;

    // Default depth of the character ring.
    localparam int QUEUE_DEPTH_DEF = 256;

    // Depth of the operation queue between the front and back parts.
    localparam int OP_QUEUE_DEPTH = 4;
    localparam int OPQ_AW         = $clog2(OP_QUEUE_DEPTH);

    // Input action codes.
    localparam logic ACT_SCANCODE = 1'b0;
    localparam logic ACT_READ     = 1'b1;

    // Set-1 scancodes with special handling.
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
    localparam logic [7:0] SC_F1           = 8'h3B;
    localparam logic [7:0] SC_F2           = 8'h3C;
    localparam logic [7:0] SC_F3           = 8'h3D;
    localparam logic [7:0] SC_F4           = 8'h3E;
    localparam logic [7:0] SC_UP           = 8'h48;
    localparam logic [7:0] SC_DOWN         = 8'h50;
    localparam logic [7:0] SC_LEFT         = 8'h4B;
    localparam logic [7:0] SC_RIGHT        = 8'h4D;
    localparam int         SC_BREAK_BIT    = 7;
    localparam logic [7:0] MAP_SIZE        = 8'd58;

    // Character codes for function and arrow keys.
    localparam logic [7:0] CH_F1    = 8'h81;
    localparam logic [7:0] CH_F2    = 8'h82;
    localparam logic [7:0] CH_F3    = 8'h83;
    localparam logic [7:0] CH_F4    = 8'h84;
    localparam logic [7:0] CH_UP    = 8'h90;
    localparam logic [7:0] CH_DOWN  = 8'h91;
    localparam logic [7:0] CH_LEFT  = 8'h92;
    localparam logic [7:0] CH_RIGHT = 8'h93;
    localparam logic [7:0] CH_NONE  = 8'h00;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_CASE  = 8'h20;

    // Unshifted key table, padded to 64 entries with zeros.
    localparam logic [7:0] PLAIN_MAP [64] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Shifted key table, padded to 64 entries with zeros.
    localparam logic [7:0] SHIFTED_MAP [64] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // One input item.
    typedef struct packed {
        logic       action;
        logic [7:0] scancode;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] character;
        logic       queue_empty;
    } t_out_item;

    // An operation for the back part: a push of one character or a read.
    typedef struct packed {
        logic       is_read;
        logic [7:0] ch;
    } t_op;

    // An operation together with its valid flag.
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_op_req;

endpackage

`default_nettype wire

// ===== rtl/scancode_to_ascii_key_queue.sv =====
// ---------------------------------------------------------------------------
// scancode_to_ascii_key_queue
// Set-1 scancode translator feeding a character ring with read requests.
// ---------------------------------------------------------------------------
// Input channel (i_valid, o_stall, i_data) carries either a scancode or a
// read request. Scancodes update shift and caps lock or push a character;
// they give no result. Every read gives one result on the output channel
// (o_valid, i_stall, o_data): the oldest character, or zero with
// queue_empty set. A full ring drops new characters.
// A read accepted at the input is registered in the operation queue and then
// in the result register. Throughput is one item per cycle unless a result
// stalls, set by the back part: one ring memory access per operation.
// Reset clears the modifiers, ring indices and operation queue; the ring
// memory itself is not cleared and needs no sweep.
// When a valid result is stalled, the result register holds and the back part
// halts; the four-entry operation queue then fills and o_stall rises.
// ---------------------------------------------------------------------------
`default_nettype none

module scancode_to_ascii_key_queue #(
    parameter int QUEUE_DEPTH = sakq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  sakq_pkg::t_in_item     i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output sakq_pkg::t_out_item    o_data
);

    sakq_pkg::t_op_req front_req;
    sakq_pkg::t_op_req q_head;
    logic              q_full;
    logic              q_pop;

    assign o_stall = q_full;

    // Front part: accept and classify.
    sakq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_req    (front_req)
    );

    // Operation queue between the parts.
    sakq_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (front_req),
        .o_full  (q_full),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    // Back part: ring access and result register.
    sakq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

// ===== rtl/sakq_front.sv =====
// ---------------------------------------------------------------------------
// sakq_front
// Accepts input items, tracks shift and caps lock and turns each item into a
// push or read operation for the back part, or drops it.
// ---------------------------------------------------------------------------
`default_nettype none

module sakq_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  sakq_pkg::t_in_item     i_data,
    input  wire logic              i_q_full,
    output sakq_pkg::t_op_req      o_req
);

    logic r_shift;
    logic r_caps;
    logic n_shift;
    logic n_caps;
    logic accept;
    logic [7:0] sc;
    logic [7:0] ch;
    logic is_mod;

    assign accept = i_valid && !i_q_full;
    assign sc     = i_data.scancode;

    // Translate a make code into a character using the current modifiers.
    always_comb begin
        ch = sakq_pkg::CH_NONE;
        case (sc)
            sakq_pkg::SC_F1:    ch = sakq_pkg::CH_F1;
            sakq_pkg::SC_F2:    ch = sakq_pkg::CH_F2;
            sakq_pkg::SC_F3:    ch = sakq_pkg::CH_F3;
            sakq_pkg::SC_F4:    ch = sakq_pkg::CH_F4;
            sakq_pkg::SC_UP:    ch = sakq_pkg::CH_UP;
            sakq_pkg::SC_DOWN:  ch = sakq_pkg::CH_DOWN;
            sakq_pkg::SC_LEFT:  ch = sakq_pkg::CH_LEFT;
            sakq_pkg::SC_RIGHT: ch = sakq_pkg::CH_RIGHT;
            default: begin
                if (sc < sakq_pkg::MAP_SIZE) begin
                    if (r_shift) begin
                        ch = sakq_pkg::SHIFTED_MAP[sc[5:0]];
                    end else begin
                        ch = sakq_pkg::PLAIN_MAP[sc[5:0]];
                        if (r_caps && ch >= sakq_pkg::CH_LC_A && ch <= sakq_pkg::CH_LC_Z) begin
                            ch = ch ^ sakq_pkg::CH_CASE;
                        end
                    end
                end
            end
        endcase
    end

    // Classify the item: modifier update, ignored code, push or read.
    always_comb begin
        n_shift = r_shift;
        n_caps  = r_caps;
        is_mod  = 1'b1;
        case (sc)
            sakq_pkg::SC_LSHIFT_MAKE, sakq_pkg::SC_RSHIFT_MAKE:   n_shift = 1'b1;
            sakq_pkg::SC_LSHIFT_BREAK, sakq_pkg::SC_RSHIFT_BREAK: n_shift = 1'b0;
            sakq_pkg::SC_CAPS_MAKE:                               n_caps  = !r_caps;
            default:                                              is_mod  = 1'b0;
        endcase

        o_req.op.is_read = (i_data.action == sakq_pkg::ACT_READ);
        o_req.op.ch      = ch;
        if (i_data.action == sakq_pkg::ACT_READ) begin
            o_req.valid = accept;
        end else begin
            o_req.valid = accept && !is_mod && !sc[sakq_pkg::SC_BREAK_BIT]
                          && (ch != sakq_pkg::CH_NONE);
        end
        if (i_data.action == sakq_pkg::ACT_READ) begin
            n_shift = r_shift;
            n_caps  = r_caps;
        end
    end

    // Modifier state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
        end else if (accept) begin
            r_shift <= n_shift;
            r_caps  <= n_caps;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sakq_opq.sv =====
// ---------------------------------------------------------------------------
// sakq_opq
// Short operation queue that decouples the front part from the back part.
// ---------------------------------------------------------------------------
`default_nettype none

module sakq_opq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  sakq_pkg::t_op_req      i_req,
    output logic                   o_full,
    output sakq_pkg::t_op_req      o_head,
    input  wire logic              i_pop
);

    localparam int CW = $clog2(sakq_pkg::OP_QUEUE_DEPTH + 1);

    sakq_pkg::t_op                r_slot [sakq_pkg::OP_QUEUE_DEPTH];
    logic [sakq_pkg::OPQ_AW-1:0]  r_wr_ptr;
    logic [sakq_pkg::OPQ_AW-1:0]  r_rd_ptr;
    logic [CW-1:0]                r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full       = (r_count == CW'(sakq_pkg::OP_QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.op    = r_slot[r_rd_ptr];
    assign do_push      = i_req.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_req.op;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sakq_back.sv =====
// ---------------------------------------------------------------------------
// sakq_back
// Carries out push and read operations on the character ring and holds the
// result register of the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

module sakq_back #(
    parameter int QUEUE_DEPTH = sakq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  sakq_pkg::t_op_req      i_head,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output sakq_pkg::t_out_item    o_data
);

    localparam int IW = $clog2(QUEUE_DEPTH);

    logic [7:0]    r_mem [QUEUE_DEPTH];
    logic [IW-1:0] r_rd_idx;
    logic [IW-1:0] r_wr_idx;
    logic [IW-1:0] rd_next;
    logic [IW-1:0] wr_next;
    logic          r_out_valid;
    logic          r_empty;
    logic [7:0]    r_rdata;
    logic          can_go;
    logic          ring_empty;
    logic          do_read;
    logic          do_write;

    assign rd_next = (r_rd_idx == IW'(QUEUE_DEPTH - 1)) ? '0 : IW'(r_rd_idx + 1'b1);
    assign wr_next = (r_wr_idx == IW'(QUEUE_DEPTH - 1)) ? '0 : IW'(r_wr_idx + 1'b1);

    // The result register frees up when it is empty or its transfer completes.
    assign can_go     = !r_out_valid || !i_stall;
    assign o_pop      = i_head.valid && can_go;
    assign ring_empty = (r_rd_idx == r_wr_idx);
    assign do_read    = o_pop && i_head.op.is_read;
    assign do_write   = o_pop && !i_head.op.is_read && (wr_next != r_rd_idx);

    // Ring indices and result control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_write) begin
                r_wr_idx <= wr_next;
            end
            if (do_read) begin
                r_out_valid <= 1'b1;
                if (!ring_empty) begin
                    r_rd_idx <= rd_next;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Ring memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_wr_idx] <= i_head.op.ch;
        end
        if (do_read) begin
            r_rdata <= r_mem[r_rd_idx];
            r_empty <= ring_empty;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_data.character   = r_empty ? sakq_pkg::CH_NONE : r_rdata;
    assign o_data.queue_empty = r_empty;

endmodule

`default_nettype wire

// ===== rtl/sakq_checker.sv =====
// ---------------------------------------------------------------------------
// sakq_checker
// Port-level assertions for the scancode key queue, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "scancode_to_ascii_key_queue_macros.svh"

module sakq_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input sakq_pkg::t_in_item     i_data,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input sakq_pkg::t_out_item    o_data
);

    // No result is offered straight after a reset cycle.
    `SAKQ_ASSERT(a_no_result_after_reset, !i_rst_n |=> !o_valid, "result valid after reset")

    // The input channel is open straight after a reset cycle.
    `SAKQ_ASSERT(a_open_after_reset, !$past(i_rst_n) |-> !o_stall, "input stalled after reset")

    // An empty read always reports a zero character.
    `SAKQ_ASSERT_RUN(a_empty_is_zero,
        o_valid && o_data.queue_empty |-> o_data.character == sakq_pkg::CH_NONE,
        "empty read with nonzero character")

    // A stalled result stays offered and unchanged.
    `SAKQ_ASSERT_RUN(a_stalled_result_holds,
        o_valid && i_stall |=> o_valid && $stable(o_data),
        "stalled result changed")

    // A stalled input transfer stays offered and unchanged.
    `SAKQ_ASSERT_RUN(a_stalled_item_holds,
        i_valid && o_stall |=> i_valid && $stable(i_data),
        "stalled input item changed")

endmodule

bind scancode_to_ascii_key_queue sakq_checker u_sakq_checker (.*);

`default_nettype wire
